/* sv/fwbs_pkg.sv */
package fwbs_pkg;

	localparam int MAX_WIDTH_C  = 256;
	localparam int MAX_HEIGHT_C = 256;
	localparam int MAX_WINDOW_C = 4;

	localparam int POS_W      = 8;
	localparam int PIX_W      = 16;
	localparam int FLOW_W     = 16;
	localparam int FRAC_W     = 8;
	localparam int COORD_W    = 9;
	localparam int CFG_W      = 9;
	localparam int IDX_W      = 2;
	localparam int WIN_W      = 3;
	localparam int WGT_W      = 17;
	localparam int SAMPLE_W   = 28;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd256;
	localparam logic [WIN_W-1:0] WINDOW_RST = 3'd1;

	localparam logic signed [63:0] OUT_MAX = 64'sd134217727;
	localparam logic signed [63:0] OUT_MIN = -64'sd134217728;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_WINDOW = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] w_m1;
		logic [COORD_W-1:0] h_m1;
		logic [WIN_W-1:0]   k_m1;
	} geom_t;

	typedef struct packed {
		logic             clear;
		logic             issue;
		logic [WGT_W-1:0] weight;
	} mac_cmd_t;

endpackage

/* sv/flow_warp_bilinear_sampler_unit.sv */
// Bilinear backward warp by a Q8.8 flow vector over one stored image plane of
// signed 16-bit pixels. A write request (tuser low) stores one pixel; writes
// outside the configured width and height are dropped. A sample request (tuser
// high) reads four corner pixels for each tap of a k by k window, where k is
// the clamped window size: after a setup step the single-port image memory
// delivers one corner pixel per cycle and a single multiply-accumulate unit
// consumes them; after the read, multiply and accumulate registers drain, the
// result is loaded in the output register. The input is not ready while a sample
// is in progress; a finished result waits in the output register without blocking
// the next request. The result is the window sum with 8 fractional bits, rounded
// toward minus infinity. The memory holds no defined value until written.
module flow_warp_bilinear_sampler_unit #(
	parameter int MAX_WIDTH  = fwbs_pkg::MAX_WIDTH_C,
	parameter int MAX_HEIGHT = fwbs_pkg::MAX_HEIGHT_C,
	parameter int MAX_WINDOW = fwbs_pkg::MAX_WINDOW_C
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x[7:0], pos_y[15:8], pixel_value[31:16], flow_x[47:32], flow_y[63:48]
	input  logic [fwbs_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// sample_value[27:0], out_x[35:28], out_y[43:36], zero[47:44]
	output logic [fwbs_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [fwbs_pkg::IDX_W-1:0]      cfg_index,
	input  logic [fwbs_pkg::CFG_W-1:0]      cfg_data
);
	import fwbs_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [WIN_W-1:0]    window_q;
	geom_t               geom;
	logic                out_free;
	logic                load;
	logic [POS_W-1:0]    res_x;
	logic [POS_W-1:0]    res_y;
	logic                store_we;
	logic [AW-1:0]       store_addr;
	logic [PIX_W-1:0]    store_wdata;
	logic [PIX_W-1:0]    store_rdata;
	mac_cmd_t            mac_cmd;
	logic                mac_busy;
	logic [SAMPLE_W-1:0] mac_result;
	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [POS_W-1:0]    out_x_q;
	logic [POS_W-1:0]    out_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			geom.w_m1 = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			geom.w_m1 = COORD_W'(MAX_WIDTH - 1);
		end else begin
			geom.w_m1 = width_q - 9'd1;
		end
		if (height_q == '0) begin
			geom.h_m1 = '0;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			geom.h_m1 = COORD_W'(MAX_HEIGHT - 1);
		end else begin
			geom.h_m1 = height_q - 9'd1;
		end
		if (window_q == '0) begin
			geom.k_m1 = '0;
		end else if (int'(window_q) > MAX_WINDOW) begin
			geom.k_m1 = WIN_W'(MAX_WINDOW - 1);
		end else begin
			geom.k_m1 = window_q - 3'd1;
		end
	end

	fwbs_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.geom        (geom),
		.out_free    (out_free),
		.load        (load),
		.out_x       (res_x),
		.out_y       (res_y),
		.store_we    (store_we),
		.store_addr  (store_addr),
		.store_wdata (store_wdata),
		.mac_cmd     (mac_cmd),
		.mac_busy    (mac_busy)
	);

	fwbs_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.addr  (store_addr),
		.wdata (store_wdata),
		.rdata (store_rdata)
	);

	fwbs_mac #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.pix    (store_rdata),
		.busy   (mac_busy),
		.result (mac_result)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= mac_result;
			out_x_q  <= res_x;
			out_y_q  <= res_y;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_y_q, out_x_q, sample_q};

endmodule

/* sv/fwbs_store.sv */
module fwbs_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             addr,
	input  logic [fwbs_pkg::PIX_W-1:0] wdata,
	output logic [fwbs_pkg::PIX_W-1:0] rdata
);
	import fwbs_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/fwbs_mac.sv */
module fwbs_mac #(
	parameter int MAX_WINDOW = 4,
	localparam int PROD_W = 34,
	localparam int ACC_W  = PROD_W + 2 + 2 * $clog2(MAX_WINDOW),
	localparam int QW     = ACC_W - 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fwbs_pkg::mac_cmd_t            cmd,
	input  logic [fwbs_pkg::PIX_W-1:0]    pix,
	output logic                          busy,
	output logic [fwbs_pkg::SAMPLE_W-1:0] result
);
	import fwbs_pkg::*;

	localparam logic signed [QW-1:0] QMAX = QW'(OUT_MAX);
	localparam logic signed [QW-1:0] QMIN = QW'(OUT_MIN);

	logic                     valid_s1;
	logic                     valid_s2;
	logic [WGT_W-1:0]         weight_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [WGT_W:0]    wsig;
	logic signed [PIX_W-1:0]  psig;
	logic signed [QW-1:0]     quot;
	logic signed [QW-1:0]     sat;

	assign wsig = $signed({1'b0, weight_s1});
	assign psig = $signed(pix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= cmd.weight;
		prod_s2   <= wsig * psig;
		if (cmd.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		quot = acc_q[ACC_W-1:FRAC_W];
		if (quot > QMAX) begin
			sat = QMAX;
		end else if (quot < QMIN) begin
			sat = QMIN;
		end else begin
			sat = quot;
		end
	end

	assign busy   = valid_s1 | valid_s2;
	assign result = sat[SAMPLE_W-1:0];

endmodule

/* sv/fwbs_ctrl.sv */
module fwbs_ctrl #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_WINDOW = 4,
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
	localparam int OW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_tuser,
	input  logic [fwbs_pkg::IN_DATA_W-1:0]  s_tdata,
	input  fwbs_pkg::geom_t                 geom,
	input  logic                            out_free,
	output logic                            load,
	output logic [fwbs_pkg::POS_W-1:0]      out_x,
	output logic [fwbs_pkg::POS_W-1:0]      out_y,
	output logic                            store_we,
	output logic [AW-1:0]                   store_addr,
	output logic [fwbs_pkg::PIX_W-1:0]      store_wdata,
	output fwbs_pkg::mac_cmd_t              mac_cmd,
	input  logic                            mac_busy
);
	import fwbs_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [POS_W-1:0]         in_x;
	logic [POS_W-1:0]         in_y;
	logic [PIX_W-1:0]         in_pix;
	logic [FLOW_W-1:0]        in_fx;
	logic [FLOW_W-1:0]        in_fy;

	logic [POS_W-1:0]         px_q;
	logic [POS_W-1:0]         py_q;
	logic [FLOW_W-1:0]        fx_q;
	logic [FLOW_W-1:0]        fy_q;
	logic [COORD_W-1:0]       xl_q;
	logic [COORD_W-1:0]       xr_q;
	logic [COORD_W-1:0]       yt_q;
	logic [COORD_W-1:0]       yb_q;
	logic [FRAC_W-1:0]        a_q;
	logic [FRAC_W-1:0]        b_q;
	logic [1:0]               corner_q;
	logic [OW-1:0]            ox_q;
	logic [OW-1:0]            oy_q;

	logic signed [17:0]       xf;
	logic signed [17:0]       yf;
	logic signed [10:0]       xi;
	logic signed [10:0]       yi;
	logic [COORD_W-1:0]       xl_d;
	logic [COORD_W-1:0]       xr_d;
	logic [COORD_W-1:0]       yt_d;
	logic [COORD_W-1:0]       yb_d;

	logic [OW-1:0]            k_m1;
	logic [COORD_W-1:0]       col_base;
	logic [COORD_W-1:0]       row_base;
	logic [COORD_W:0]         col_sum;
	logic [COORD_W:0]         row_sum;
	logic [COORD_W-1:0]       col;
	logic [COORD_W-1:0]       row;
	logic [COORD_W-1:0]       wa;
	logic [COORD_W-1:0]       wb;
	logic [2*COORD_W-1:0]     wprod;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            wr_addr;
	logic                     wr_ok;
	logic                     last_tap;
	logic                     accept;

	function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [10:0] v,
			input logic [COORD_W-1:0] hi);
		logic [COORD_W-1:0] r;
		if (v < 11'sd0) begin
			r = '0;
		end else if (v > $signed({2'b00, hi})) begin
			r = hi;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	assign in_x   = s_tdata[7:0];
	assign in_y   = s_tdata[15:8];
	assign in_pix = s_tdata[31:16];
	assign in_fx  = s_tdata[47:32];
	assign in_fy  = s_tdata[63:48];

	assign xf   = $signed({2'b00, px_q, 8'h00}) + $signed({{2{fx_q[FLOW_W-1]}}, fx_q});
	assign yf   = $signed({2'b00, py_q, 8'h00}) + $signed({{2{fy_q[FLOW_W-1]}}, fy_q});
	assign xi   = {xf[17], xf[17:8]};
	assign yi   = {yf[17], yf[17:8]};
	assign xl_d = clamp_coord(xi, geom.w_m1);
	assign xr_d = clamp_coord(xi + 11'sd1, geom.w_m1);
	assign yt_d = clamp_coord(yi, geom.h_m1);
	assign yb_d = clamp_coord(yi + 11'sd1, geom.h_m1);

	assign k_m1     = OW'(geom.k_m1);
	assign col_base = corner_q[0] ? xr_q : xl_q;
	assign row_base = corner_q[1] ? yb_q : yt_q;
	assign col_sum  = {1'b0, col_base} + (COORD_W + 1)'(ox_q);
	assign row_sum  = {1'b0, row_base} + (COORD_W + 1)'(oy_q);
	assign col      = (col_sum > {1'b0, geom.w_m1}) ? geom.w_m1 : col_sum[COORD_W-1:0];
	assign row      = (row_sum > {1'b0, geom.h_m1}) ? geom.h_m1 : row_sum[COORD_W-1:0];
	assign wa       = corner_q[0] ? {1'b0, a_q} : 9'd256 - {1'b0, a_q};
	assign wb       = corner_q[1] ? {1'b0, b_q} : 9'd256 - {1'b0, b_q};
	assign wprod    = wa * wb;
	assign rd_addr  = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
	assign wr_addr  = AW'(in_y) * AW'(MAX_WIDTH) + AW'(in_x);
	assign wr_ok    = ({1'b0, in_x} <= geom.w_m1) && ({1'b0, in_y} <= geom.h_m1);
	assign last_tap = (corner_q == 2'd3) && (ox_q == k_m1) && (oy_q == k_m1);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		s_tready       = 1'b0;
		load           = 1'b0;
		store_we       = 1'b0;
		store_addr     = rd_addr;
		mac_cmd.clear  = 1'b0;
		mac_cmd.issue  = 1'b0;
		mac_cmd.weight = wprod[WGT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				store_addr = wr_addr;
				if (s_tvalid) begin
					if (s_tuser == OP_SAMPLE) begin
						state_d = ST_SETUP;
					end else begin
						store_we = wr_ok;
					end
				end
			end
			ST_SETUP: begin
				mac_cmd.clear = 1'b1;
				state_d       = ST_RUN;
			end
			ST_RUN: begin
				mac_cmd.issue = 1'b1;
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= in_x;
			py_q <= in_y;
			fx_q <= in_fx;
			fy_q <= in_fy;
		end
		if (state_q == ST_SETUP) begin
			xl_q     <= xl_d;
			xr_q     <= xr_d;
			yt_q     <= yt_d;
			yb_q     <= yb_d;
			a_q      <= xf[FRAC_W-1:0];
			b_q      <= yf[FRAC_W-1:0];
			corner_q <= 2'd0;
			ox_q     <= '0;
			oy_q     <= '0;
		end else if (state_q == ST_RUN) begin
			corner_q <= corner_q + 2'd1;
			if (corner_q == 2'd3) begin
				if (ox_q == k_m1) begin
					ox_q <= '0;
					oy_q <= oy_q + OW'(1);
				end else begin
					ox_q <= ox_q + OW'(1);
				end
			end
		end
	end

	assign store_wdata = in_pix;
	assign out_x       = px_q;
	assign out_y       = py_q;

endmodule

/* sv/fwbs_checker.sv */
module fwbs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [fwbs_pkg::OUT_DATA_W-1:0] m_tdata
);
	import fwbs_pkg::*;

	logic wr_req;
	logic smp_req;

	assign wr_req  = s_tvalid && s_tready && (s_tuser == OP_WRITE);
	assign smp_req = s_tvalid && s_tready && (s_tuser == OP_SAMPLE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_req && !m_tvalid |=> !m_tvalid)
		else $error("write request produced a result");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_req |=> !s_tready)
		else $error("ready right after a sample request");

	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		wr_req |=> s_tready)
		else $error("write request stalled the input");

endmodule

bind flow_warp_bilinear_sampler_unit fwbs_checker u_fwbs_checker (.*);

/* verif/flow_warp_bilinear_sampler_unit_tb.sv */
`timescale 1ns / 100ps

module flow_warp_bilinear_sampler_unit_tb;
	import fwbs_pkg::*;

	localparam int SETTLE_CYCLES = 4 * MAX_WINDOW_C * MAX_WINDOW_C + 16;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_REQUESTS = 40;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic [POS_W-1:0]           x;
		logic [POS_W-1:0]           y;
	} sample_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	logic signed [PIX_W-1:0] image_mirror [MAX_WIDTH_C*MAX_HEIGHT_C];
	logic [CFG_W-1:0]        width_reg = WIDTH_RST;
	logic [CFG_W-1:0]        height_reg = HEIGHT_RST;
	logic [WIN_W-1:0]        window_reg = WINDOW_RST;
	sample_result_t          pending_samples[$];
	sample_result_t          due_result;
	int                      failures = 0;
	int                      burst_left = 0;
	int                      hold_off_cycles = 0;

	flow_warp_bilinear_sampler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int clip(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int active_width();
		return clip(int'(width_reg), 1, MAX_WIDTH_C);
	endfunction

	function automatic int active_height();
		return clip(int'(height_reg), 1, MAX_HEIGHT_C);
	endfunction

	function automatic int active_window();
		return clip(int'(window_reg), 1, MAX_WINDOW_C);
	endfunction

	function automatic longint texel(input int row, input int col, input int w, input int h);
		return longint'(image_mirror[clip(row, 0, h - 1) * MAX_WIDTH_C + clip(col, 0, w - 1)]);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] warped_window_sum(
		input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
		input logic signed [FLOW_W-1:0] fx, input logic signed [FLOW_W-1:0] fy);
		int w, h, k, xq, yq, xi, yi, a, b, xl, xr, yt, yb;
		longint wt_tl, wt_tr, wt_bl, wt_br, acc;
		w = active_width();
		h = active_height();
		k = active_window();
		xq = int'(px) * 256 + int'(fx);
		yq = int'(py) * 256 + int'(fy);
		xi = xq >>> FRAC_W;
		yi = yq >>> FRAC_W;
		a = xq & 255;
		b = yq & 255;
		xl = clip(xi, 0, w - 1);
		xr = clip(xi + 1, 0, w - 1);
		yt = clip(yi, 0, h - 1);
		yb = clip(yi + 1, 0, h - 1);
		wt_tl = longint'(256 - a) * longint'(256 - b);
		wt_tr = longint'(a) * longint'(256 - b);
		wt_bl = longint'(256 - a) * longint'(b);
		wt_br = longint'(a) * longint'(b);
		acc = 0;
		for (int dy = 0; dy < k; dy++) begin
			for (int dx = 0; dx < k; dx++) begin
				acc += wt_tl * texel(yt + dy, xl + dx, w, h);
				acc += wt_tr * texel(yt + dy, xr + dx, w, h);
				acc += wt_bl * texel(yb + dy, xl + dx, w, h);
				acc += wt_br * texel(yb + dy, xr + dx, w, h);
			end
		end
		acc = acc >>> FRAC_W;
		if (acc > OUT_MAX)
			acc = OUT_MAX;
		if (acc < OUT_MIN)
			acc = OUT_MIN;
		return acc[SAMPLE_W-1:0];
	endfunction

	function automatic void account_request(input opcode_t op,
		input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
		input logic [PIX_W-1:0] pv, input logic [FLOW_W-1:0] fx, input logic [FLOW_W-1:0] fy);
		sample_result_t r;
		if (op == OP_WRITE) begin
			if (int'(px) < active_width() && int'(py) < active_height())
				image_mirror[int'(py) * MAX_WIDTH_C + int'(px)] = pv;
		end else begin
			r.value = warped_window_sum(px, py, fx, fy);
			r.x = px;
			r.y = py;
			pending_samples.push_back(r);
		end
	endfunction

	// Send one request with bursty valid, then record it once accepted.
	task automatic send_request(input opcode_t op,
		input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
		input logic [PIX_W-1:0] pv, input logic [FLOW_W-1:0] fx, input logic [FLOW_W-1:0] fy);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tuser <= op;
		s_tdata <= {fy, fx, pv, py, px};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		account_request(op, px, py, pv, fx, fy);
	endtask

	// Drop valid, drain outstanding samples, then let the block go quiet.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input reg_index_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH: width_reg = value;
			REG_HEIGHT: height_reg = value;
			default: window_reg = value[WIN_W-1:0];
		endcase
	endtask

	task automatic set_geometry(input int w, input int h, input int k);
		settle();
		write_register(REG_WIDTH, CFG_W'(w));
		write_register(REG_HEIGHT, CFG_W'(h));
		write_register(REG_WINDOW, CFG_W'(k));
	endtask

	task automatic fill_plane(input int cols, input int rows, input bit uniform,
		input logic [PIX_W-1:0] level);
		logic [PIX_W-1:0] pv;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				if (uniform)
					pv = level;
				else begin
					case ($urandom_range(0, 7))
						0: pv = 16'h8000;
						1: pv = 16'h7FFF;
						default: pv = PIX_W'($urandom);
					endcase
				end
				send_request(OP_WRITE, POS_W'(c), POS_W'(r), pv,
					FLOW_W'($urandom), FLOW_W'($urandom));
			end
		end
	endtask

	task automatic random_traffic(input int count);
		int w, h;
		logic [POS_W-1:0] px, py;
		logic [FLOW_W-1:0] fx, fy;
		w = active_width();
		h = active_height();
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) begin
				px = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) :
					POS_W'($urandom_range(0, clip(w + 2, 0, 255)));
				py = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) :
					POS_W'($urandom_range(0, clip(h + 2, 0, 255)));
				send_request(OP_WRITE, px, py, PIX_W'($urandom),
					FLOW_W'($urandom), FLOW_W'($urandom));
			end else begin
				px = ($urandom_range(0, 4) == 0) ? POS_W'($urandom) :
					POS_W'($urandom_range(0, clip(w + 1, 0, 255)));
				py = ($urandom_range(0, 4) == 0) ? POS_W'($urandom) :
					POS_W'($urandom_range(0, clip(h + 1, 0, 255)));
				case ($urandom_range(0, 2))
					0: begin
						fx = FLOW_W'($urandom);
						fy = FLOW_W'($urandom);
					end
					1: begin
						fx = FLOW_W'($urandom_range(0, 2047) - 1024);
						fy = FLOW_W'($urandom_range(0, 2047) - 1024);
					end
					default: begin
						fx = FLOW_W'($urandom_range(0, 255));
						fy = FLOW_W'($urandom_range(0, 255));
					end
				endcase
				send_request(OP_SAMPLE, px, py, PIX_W'($urandom), fx, fy);
			end
		end
	endtask

	// Reset geometry is the full plane; keep every tap inside a 3x3 corner.
	task automatic test_reset_geometry();
		fill_plane(3, 3, 1'b0, '0);
		repeat (8)
			send_request(OP_SAMPLE, POS_W'($urandom_range(0, 1)),
				POS_W'($urandom_range(0, 1)), PIX_W'($urandom),
				FLOW_W'($urandom_range(0, 1279) - 1024),
				FLOW_W'($urandom_range(0, 1279) - 1024));
	endtask

	task automatic test_directed_cases();
		set_geometry(2, 2, 4);
		fill_plane(2, 2, 1'b1, 16'h8000);
		send_request(OP_SAMPLE, 0, 0, 16'h0000, 16'h0080, 16'h0040);
		fill_plane(2, 2, 1'b1, 16'h7FFF);
		send_request(OP_SAMPLE, 1, 1, 16'h0000, 16'h7FFF, 16'h8000);
		send_request(OP_SAMPLE, 255, 255, 16'h0000, 16'h8000, 16'h7FFF);
		send_request(OP_WRITE, 2, 0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_WRITE, 0, 2, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_WRITE, 255, 255, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_request(OP_SAMPLE, 0, 0, 16'h0000, 16'h00FF, 16'hFFFF);
		send_request(OP_WRITE, 1, 0, 16'h8000, 16'h1234, 16'hEDCB);
		send_request(OP_SAMPLE, 0, 0, 16'hFFFF, 16'h0000, 16'h0000);
		set_geometry(2, 2, 1);
		send_request(OP_SAMPLE, 0, 0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_SAMPLE, 0, 0, 16'h0000, 16'h0080, 16'h0080);
		send_request(OP_SAMPLE, 1, 0, 16'h0000, 16'hFF01, 16'h0000);
	endtask

	// Out-of-range register values, which also reach the width and height extremes.
	task automatic test_register_ranges();
		set_geometry(0, 511, 0);
		fill_plane(active_width(), active_height(), 1'b0, '0);
		random_traffic(30);
		set_geometry(300, 0, 7);
		fill_plane(active_width(), active_height(), 1'b0, '0);
		random_traffic(30);
	endtask

	task automatic test_random_geometry();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_geometry($urandom_range(1, 20), $urandom_range(1, 12), $urandom_range(1, 4));
			fill_plane(active_width(), active_height(), 1'b0, '0);
			random_traffic(PHASE_REQUESTS);
		end
	endtask

	// Hold off the result side long enough for the block to stall its input.
	task automatic test_backpressure();
		set_geometry(6, 5, 2);
		fill_plane(active_width(), active_height(), 1'b0, '0);
		hold_off_cycles = 400;
		random_traffic(40);
	endtask

	initial begin : result_sink
		int stall_mode;
		int mode_cycles;
		int hold_left;
		stall_mode = 0;
		mode_cycles = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles != 0) begin
				hold_left = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_cycles == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_cycles = $urandom_range(8, 80);
				end
				mode_cycles--;
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((mode_cycles % 8) < 5);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected result: m_tdata %h", m_tdata);
				failures++;
			end else begin
				due_result = pending_samples.pop_front();
				if ($signed(m_tdata[SAMPLE_W-1:0]) !== due_result.value) begin
					$error("sample_value: expected %0d, got %0d", due_result.value,
						$signed(m_tdata[SAMPLE_W-1:0]));
					failures++;
				end
				if (m_tdata[SAMPLE_W+POS_W-1:SAMPLE_W] !== due_result.x) begin
					$error("out_x: expected %0d, got %0d", due_result.x,
						m_tdata[SAMPLE_W+POS_W-1:SAMPLE_W]);
					failures++;
				end
				if (m_tdata[SAMPLE_W+2*POS_W-1:SAMPLE_W+POS_W] !== due_result.y) begin
					$error("out_y: expected %0d, got %0d", due_result.y,
						m_tdata[SAMPLE_W+2*POS_W-1:SAMPLE_W+POS_W]);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_directed_cases();
		test_register_ranges();
		test_random_geometry();
		test_backpressure();
		settle();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
sv/fwbs_pkg.sv
sv/fwbs_store.sv
sv/fwbs_mac.sv
sv/fwbs_ctrl.sv
sv/flow_warp_bilinear_sampler_unit.sv
sv/fwbs_checker.sv
verif/flow_warp_bilinear_sampler_unit_tb.sv
